>>> design/rse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rse_pkg
// Shared types and constants for the RPN stack evaluator.
// ----------------------------------------------------------------------------
package rse_pkg;

	localparam int unsigned DEFAULT_STACK_DEPTH = 128;
	localparam int unsigned VAL_W = 64;

	typedef enum logic [2:0] {
		FUNC_PUSH = 3'd0,
		FUNC_ADD  = 3'd1,
		FUNC_SUB  = 3'd2,
		FUNC_MUL  = 3'd3,
		FUNC_DIV  = 3'd4
	} func_t;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_INVALID   = 3'd1;
	localparam logic [2:0] ST_OVERFLOW  = 3'd2;
	localparam logic [2:0] ST_UNDERFLOW = 3'd3;
	localparam logic [2:0] ST_SAT       = 3'd4;

	localparam logic [63:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MIN_NEG = 64'h8000_0000_0000_0000;

	typedef enum logic [3:0] {
		S_IDLE, S_READ_Y, S_READ_X, S_CALC, S_MUL, S_DIV, S_WRITE, S_OUT
	} state_t;

	// input word: one token
	typedef struct packed {
		logic [2:0]  func;
		logic [63:0] push_value;
	} token_t;

	// output word: stack after the token
	typedef struct packed {
		logic [63:0] top_value;
		logic        is_empty;
		logic [7:0]  depth;
		logic [2:0]  status;
	} stack_view_t;

	typedef struct packed {
		logic        start;
		logic [2:0]  func;
		logic [63:0] x;
		logic [63:0] y;
	} alu_req_t;

	typedef struct packed {
		logic        done;
		logic        sat;
		logic [63:0] result;
	} alu_rsp_t;

endpackage
`default_nettype wire

>>> design/rse_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rse_stream_if
// Valid/ready channel carrying a payload word.
// ----------------------------------------------------------------------------
interface rse_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/rse_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rse_alu
// Shared iterative Q32.32 arithmetic: multiply as four 32x32 partial
// products, divide by restoring radix-2 over 128 steps.
// ----------------------------------------------------------------------------
module rse_alu (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rse_pkg::alu_req_t req,
	output rse_pkg::alu_rsp_t      rsp
);

	typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_FIN} astate_t;

	astate_t      st_q;
	logic [63:0]  a_q, b_q;
	logic         neg_q;
	logic [127:0] acc_q;
	logic [1:0]   pp_q;
	logic [6:0]   cnt_q;
	logic [127:0] num_q;
	logic [63:0]  rem_q;
	logic [63:0]  quo_q;
	logic         big_q;
	logic         is_div_q;

	logic [63:0] mag_x, mag_y;
	logic [31:0] pa, pb;
	logic [63:0] pp;
	logic [127:0] pp_sh;
	logic [63:0] rem_sh;
	logic        carry;
	logic        ge;
	logic [63:0] mag;
	logic        big;
	logic [63:0] sres;
	logic        ssat;

	assign mag_x = req.x[63] ? (64'd0 - req.x) : req.x;
	assign mag_y = req.y[63] ? (64'd0 - req.y) : req.y;

	always_comb begin
		pa = pp_q[1] ? a_q[63:32] : a_q[31:0];
		pb = pp_q[0] ? b_q[63:32] : b_q[31:0];
		pp = 64'(pa) * 64'(pb);
		pp_sh = 128'(pp) << ({6'd0, pp_q[1]} + {6'd0, pp_q[0]}) * 7'd32;
		carry = rem_q[63];
		rem_sh = {rem_q[62:0], num_q[127]};
		ge = carry || (rem_sh >= b_q);
	end

	always_comb begin
		if (is_div_q) begin
			mag = quo_q;
			big = big_q;
		end else begin
			mag = acc_q[95:32];
			big = acc_q[127:96] != 32'd0;
		end
		ssat = 1'b0;
		if (neg_q) begin
			if (big || mag > rse_pkg::MIN_NEG) begin
				ssat = 1'b1;
				sres = rse_pkg::MIN_NEG;
			end else begin
				sres = 64'd0 - mag;
			end
		end else begin
			if (big || mag > rse_pkg::MAX_POS) begin
				ssat = 1'b1;
				sres = rse_pkg::MAX_POS;
			end else begin
				sres = mag;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= A_IDLE;
			rsp      <= '0;
			a_q      <= '0;
			b_q      <= '0;
			neg_q    <= 1'b0;
			acc_q    <= '0;
			pp_q     <= 2'd0;
			cnt_q    <= 7'd0;
			num_q    <= '0;
			rem_q    <= '0;
			quo_q    <= '0;
			big_q    <= 1'b0;
			is_div_q <= 1'b0;
		end else begin
			rsp.done <= st_q == A_FIN;
			unique case (st_q)
				A_IDLE: begin
					if (req.start) begin
						a_q      <= mag_x;
						b_q      <= mag_y;
						neg_q    <= req.x[63] ^ req.y[63];
						acc_q    <= '0;
						pp_q     <= 2'd0;
						cnt_q    <= 7'd0;
						num_q    <= {32'd0, mag_x, 32'd0};
						rem_q    <= '0;
						quo_q    <= '0;
						big_q    <= 1'b0;
						is_div_q <= req.func == rse_pkg::FUNC_DIV;
						st_q     <= (req.func == rse_pkg::FUNC_DIV) ? A_DIV : A_MUL;
					end
				end
				A_MUL: begin
					acc_q <= acc_q + pp_sh;
					pp_q  <= pp_q + 2'd1;
					if (pp_q == 2'd3) st_q <= A_FIN;
				end
				A_DIV: begin
					num_q <= {num_q[126:0], 1'b0};
					if (ge) begin
						rem_q <= rem_sh - b_q;
						if (!cnt_q[6]) big_q <= 1'b1;
					end else begin
						rem_q <= rem_sh;
					end
					if (cnt_q[6]) quo_q <= {quo_q[62:0], ge};
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd127) st_q <= A_FIN;
				end
				A_FIN: begin
					rsp.sat    <= ssat;
					rsp.result <= sres;
					st_q       <= A_IDLE;
				end
				default: st_q <= A_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> design/rpn_stack_evaluator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_unit
// RPN evaluator over a Q32.32 stack held in a one-read one-write memory.
// ----------------------------------------------------------------------------
// One word in, one word out per token. From acceptance to the result word: a
// push reads the stack, writes and reports; an invalid, underflowing,
// overflowing or halted token reads the stack and reports; add, subtract and
// divide by zero take two stack reads, a calc step and a write; multiply adds
// four 32x32 partial products in the shared unit; divide runs one quotient
// bit per cycle over 128 steps in the shared unit. The block takes the next
// word only after the result word has been taken, returning to idle in
// between. Overflow and underflow faults halt the evaluator until reset.
module rpn_stack_evaluator_unit #(
	parameter int unsigned STACK_DEPTH = rse_pkg::DEFAULT_STACK_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	rse_stream_if.sink   in_ch,
	rse_stream_if.source out_ch
);

	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

	rse_pkg::state_t st_q, st_d;
	logic [63:0] mem [STACK_DEPTH];
	logic [63:0] rd_q;
	logic [DW-1:0] depth_q;
	logic        halt_q;
	logic [2:0]  func_q;
	logic [63:0] pval_q;
	logic [63:0] x_q, y_q, top_q;
	logic [2:0]  status_q;
	logic        in_rdy;
	logic [AW-1:0] rd_addr;
	logic        full;
	rse_pkg::alu_req_t req;
	rse_pkg::alu_rsp_t rsp;
	logic [63:0] add_r, sub_r;
	logic        add_ov, sub_ov;

	assign full = depth_q >= DW'(STACK_DEPTH);
	assign in_ch.ready = in_rdy;

	always_comb begin
		in_rdy = 1'b0;
		out_ch.valid = 1'b0;
		unique case (st_q)
			rse_pkg::S_IDLE: in_rdy = 1'b1;
			rse_pkg::S_OUT:  out_ch.valid = 1'b1;
			default: ;
		endcase
	end

	assign out_ch.data.top_value = top_q;
	assign out_ch.data.is_empty  = depth_q == '0;
	assign out_ch.data.depth     = 8'(depth_q);
	assign out_ch.data.status    = status_q;

	assign add_r  = x_q + y_q;
	assign sub_r  = x_q - y_q;
	assign add_ov = (x_q[63] == y_q[63]) && (add_r[63] != x_q[63]);
	assign sub_ov = (x_q[63] != y_q[63]) && (sub_r[63] != x_q[63]);

	assign req.start = st_q == rse_pkg::S_CALC &&
		(func_q == rse_pkg::FUNC_MUL || (func_q == rse_pkg::FUNC_DIV && y_q != '0));
	assign req.func  = func_q;
	assign req.x     = x_q;
	assign req.y     = y_q;

	rse_alu u_alu (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			rse_pkg::S_IDLE:   if (in_ch.valid) st_d = rse_pkg::S_READ_Y;
			rse_pkg::S_READ_Y: begin
				if (halt_q) st_d = rse_pkg::S_OUT;
				else if (func_q == rse_pkg::FUNC_PUSH)
					st_d = full ? rse_pkg::S_OUT : rse_pkg::S_WRITE;
				else if (func_q > rse_pkg::FUNC_DIV || depth_q < DW'(2))
					st_d = rse_pkg::S_OUT;
				else st_d = rse_pkg::S_READ_X;
			end
			rse_pkg::S_READ_X: st_d = rse_pkg::S_CALC;
			rse_pkg::S_CALC: begin
				if (req.start) st_d = rse_pkg::S_MUL;
				else st_d = rse_pkg::S_WRITE;
			end
			rse_pkg::S_MUL:    if (rsp.done) st_d = rse_pkg::S_WRITE;
			rse_pkg::S_DIV:    st_d = rse_pkg::S_WRITE;
			rse_pkg::S_WRITE:  st_d = rse_pkg::S_OUT;
			rse_pkg::S_OUT:    if (out_ch.ready) st_d = rse_pkg::S_IDLE;
			default:           st_d = rse_pkg::S_IDLE;
		endcase
	end

	// read address: top entry first, then the one below
	always_comb begin
		if (st_q == rse_pkg::S_READ_Y) rd_addr = AW'(depth_q - DW'(2));
		else rd_addr = AW'(depth_q - DW'(1));
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (st_q == rse_pkg::S_WRITE) begin
			if (func_q == rse_pkg::FUNC_PUSH) mem[AW'(depth_q)] <= pval_q;
			else mem[AW'(depth_q - DW'(2))] <= top_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= rse_pkg::S_IDLE;
			depth_q  <= '0;
			halt_q   <= 1'b0;
			func_q   <= 3'd0;
			pval_q   <= '0;
			x_q      <= '0;
			y_q      <= '0;
			top_q    <= '0;
			status_q <= rse_pkg::ST_OK;
		end else begin
			st_q <= st_d;
			unique case (st_q)
				rse_pkg::S_IDLE: begin
					if (in_ch.valid) begin
						func_q <= in_ch.data.func;
						pval_q <= in_ch.data.push_value;
					end
				end
				rse_pkg::S_READ_Y: begin
					// rd_q now holds the top entry (read at depth-1 in idle)
					y_q      <= rd_q;
					top_q    <= (depth_q == '0) ? 64'd0 : rd_q;
					if (halt_q) status_q <= full ? rse_pkg::ST_OVERFLOW : rse_pkg::ST_UNDERFLOW;
					else if (func_q == rse_pkg::FUNC_PUSH) begin
						if (full) begin
							halt_q   <= 1'b1;
							status_q <= rse_pkg::ST_OVERFLOW;
						end else status_q <= rse_pkg::ST_OK;
					end else if (func_q > rse_pkg::FUNC_DIV) status_q <= rse_pkg::ST_INVALID;
					else if (depth_q < DW'(2)) begin
						halt_q   <= 1'b1;
						status_q <= rse_pkg::ST_UNDERFLOW;
					end else status_q <= rse_pkg::ST_OK;
				end
				rse_pkg::S_READ_X: x_q <= rd_q;
				rse_pkg::S_CALC: begin
					unique case (func_q)
						rse_pkg::FUNC_ADD: begin
							top_q <= add_ov ? (x_q[63] ? rse_pkg::MIN_NEG : rse_pkg::MAX_POS) : add_r;
							if (add_ov) status_q <= rse_pkg::ST_SAT;
						end
						rse_pkg::FUNC_SUB: begin
							top_q <= sub_ov ? (x_q[63] ? rse_pkg::MIN_NEG : rse_pkg::MAX_POS) : sub_r;
							if (sub_ov) status_q <= rse_pkg::ST_SAT;
						end
						rse_pkg::FUNC_DIV: begin
							// divide by zero handled here; otherwise the shared unit runs
							if (y_q == '0) begin
								status_q <= rse_pkg::ST_SAT;
								top_q <= (x_q == '0) ? 64'd0 :
									(x_q[63] ? rse_pkg::MIN_NEG : rse_pkg::MAX_POS);
							end
						end
						default: ;
					endcase
				end
				rse_pkg::S_MUL: begin
					if (rsp.done) begin
						top_q <= rsp.result;
						if (rsp.sat) status_q <= rse_pkg::ST_SAT;
					end
				end
				rse_pkg::S_WRITE: begin
					if (func_q == rse_pkg::FUNC_PUSH) begin
						depth_q <= depth_q + DW'(1);
						top_q   <= pval_q;
					end else depth_q <= depth_q - DW'(1);
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire
